// File: design/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define ASSERT_ALWAYS(label, clk, cond, conseq, msg) \
   label: assert property (@(posedge clk) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// File: design/stlex_pkg.sv
// types, codes and character classes for the source text lexer
package stlex_pkg;

   localparam int POS_BITS = 16;
   localparam int OUT_POS_W = 16;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // lexer modes
   localparam int MODE_W = 4;
   localparam logic [MODE_W-1:0] M_BEGIN = 4'd0;
   localparam logic [MODE_W-1:0] M_DOT   = 4'd1;
   localparam logic [MODE_W-1:0] M_DOOT  = 4'd2;
   localparam logic [MODE_W-1:0] M_LCOM  = 4'd3;
   localparam logic [MODE_W-1:0] M_BCOM  = 4'd4;
   localparam logic [MODE_W-1:0] M_INT   = 4'd5;
   localparam logic [MODE_W-1:0] M_DEC   = 4'd6;
   localparam logic [MODE_W-1:0] M_WORD  = 4'd7;
   localparam logic [MODE_W-1:0] M_SYM   = 4'd8;
   localparam logic [MODE_W-1:0] M_STR   = 4'd9;
   localparam logic [MODE_W-1:0] M_ESC   = 4'd10;

   // input kinds
   localparam logic IN_CHAR = 1'b0;
   localparam logic IN_END  = 1'b1;

   // events
   localparam logic [1:0] EV_TEXT = 2'd0;
   localparam logic [1:0] EV_DONE = 2'd1;
   localparam logic [1:0] EV_ERR  = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_DDOT   = 2'd1;
   localparam logic [1:0] ERR_UNTERM = 2'd2;

   // token kinds
   localparam logic [4:0] K_AT       = 5'd0;
   localparam logic [4:0] K_COLON    = 5'd1;
   localparam logic [4:0] K_SEMI     = 5'd2;
   localparam logic [4:0] K_COMMA    = 5'd3;
   localparam logic [4:0] K_DOT      = 5'd4;
   localparam logic [4:0] K_ELLIPSIS = 5'd5;
   localparam logic [4:0] K_LPAREN   = 5'd6;
   localparam logic [4:0] K_RPAREN   = 5'd7;
   localparam logic [4:0] K_LBRACK   = 5'd8;
   localparam logic [4:0] K_RBRACK   = 5'd9;
   localparam logic [4:0] K_LBRACE   = 5'd10;
   localparam logic [4:0] K_RBRACE   = 5'd11;
   localparam logic [4:0] K_QUEST    = 5'd12;
   localparam logic [4:0] K_INT      = 5'd13;
   localparam logic [4:0] K_DEC      = 5'd14;
   localparam logic [4:0] K_WORD     = 5'd15;
   localparam logic [4:0] K_SYM      = 5'd16;
   localparam logic [4:0] K_STR      = 5'd17;
   localparam logic [4:0] K_END      = 5'd18;

   // characters
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_B   = 8'h62;
   localparam logic [7:0] CH_LC_F   = 8'h66;
   localparam logic [7:0] CH_LC_N   = 8'h6E;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_T   = 8'h74;
   localparam logic [7:0] CH_LC_Z   = 8'h7A;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_Z   = 8'h5A;
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_NUL    = 8'h00;

   typedef struct packed {
      logic [1:0]           event_res;
      logic [4:0]           token_kind;
      logic [7:0]           text_byte;
      logic [1:0]           error_code;
      logic [OUT_POS_W-1:0] start_line;
      logic [OUT_POS_W-1:0] start_column;
      logic                 last_result;
   } rsp_type;

   function automatic rsp_type make_res(input logic [1:0] ev, input logic [4:0] kind,
                                        input logic [7:0] text, input logic [1:0] err,
                                        input logic [POS_BITS-1:0] ln,
                                        input logic [POS_BITS-1:0] col);
      rsp_type r;
      r.event_res    = ev;
      r.token_kind   = kind;
      r.text_byte    = text;
      r.error_code   = err;
      r.start_line   = OUT_POS_W'(ln);
      r.start_column = OUT_POS_W'(col);
      r.last_result  = 1'b0;
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_digit(c) || is_alpha(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c == CH_AT) || (c == CH_COLON) || (c == CH_SEMI) || (c == CH_COMMA) ||
             (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACK) ||
             (c == CH_RBRACK) || (c == CH_LBRACE) || (c == CH_RBRACE) ||
             (c == CH_QUEST);
   endfunction

   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      unique case (c)
         CH_AT:     k = K_AT;
         CH_COLON:  k = K_COLON;
         CH_SEMI:   k = K_SEMI;
         CH_COMMA:  k = K_COMMA;
         CH_LPAREN: k = K_LPAREN;
         CH_RPAREN: k = K_RPAREN;
         CH_LBRACK: k = K_LBRACK;
         CH_RBRACK: k = K_RBRACK;
         CH_LBRACE: k = K_LBRACE;
         CH_RBRACE: k = K_RBRACE;
         default:   k = K_QUEST;
      endcase
      return k;
   endfunction

   function automatic logic is_sym(input logic [7:0] c);
      return !(is_space(c) || is_word(c) || is_punct(c) || (c == CH_HASH) ||
               (c == CH_DOLLAR) || (c == CH_DOT) || (c == CH_QUOTE));
   endfunction

endpackage

// File: design/stlex_lexer.sv
// lexer state registers and the per-byte step logic
module stlex_lexer
   import stlex_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       step_kind,
   input  logic [7:0] step_byte,
   output rsp_type    res0,
   output rsp_type    res1,
   output logic [1:0] res_cnt
);

   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [POS_BITS-1:0] line_ff, line_in;
   logic [POS_BITS-1:0] col_ff, col_in;
   logic [POS_BITS-1:0] tok_line_ff, tok_line_in;
   logic [POS_BITS-1:0] tok_col_ff, tok_col_in;

   logic [POS_BITS-1:0] lc_n, cc_n;

   logic [MODE_W-1:0] st_mode;
   logic              st_set_tok;
   logic              st_emit;
   rsp_type           st_res;

   logic              do_close;
   logic [4:0]        close_kind;
   logic              do_start;
   rsp_type           r0, r1;
   logic [1:0]        cnt;
   logic [7:0]        esc_t;
   logic              esc_known;

   // position after counting the current byte
   always_comb begin
      lc_n = line_ff;
      cc_n = col_ff;
      if (step_byte == CH_NL) begin
         if (line_ff != POS_MAX) lc_n = line_ff + 1'b1;
         cc_n = '0;
      end else if (col_ff != POS_MAX) begin
         cc_n = col_ff + 1'b1;
      end
   end

   // byte that opens a new token
   always_comb begin
      st_mode    = M_BEGIN;
      st_set_tok = !is_space(step_byte);
      st_emit    = 1'b0;
      st_res     = make_res(EV_TEXT, K_SYM, step_byte, ERR_NONE, lc_n, cc_n);
      if (is_space(step_byte)) begin
         st_mode = M_BEGIN;
      end else if (is_punct(step_byte)) begin
         st_emit = 1'b1;
         st_res  = make_res(EV_DONE, punct_kind(step_byte), 8'd0, ERR_NONE, lc_n, cc_n);
      end else if (step_byte == CH_HASH) begin
         st_mode = M_LCOM;
      end else if (step_byte == CH_DOLLAR) begin
         st_mode = M_BCOM;
      end else if (step_byte == CH_QUOTE) begin
         st_mode = M_STR;
      end else if (step_byte == CH_DOT) begin
         st_mode = M_DOT;
      end else if (is_digit(step_byte)) begin
         st_mode = M_INT;
         st_emit = 1'b1;
         st_res  = make_res(EV_TEXT, K_INT, step_byte, ERR_NONE, lc_n, cc_n);
      end else if (is_word(step_byte)) begin
         st_mode = M_WORD;
         st_emit = 1'b1;
         st_res  = make_res(EV_TEXT, K_WORD, step_byte, ERR_NONE, lc_n, cc_n);
      end else begin
         st_mode = M_SYM;
         st_emit = 1'b1;
      end
   end

   // escape translation
   always_comb begin
      esc_known = 1'b1;
      unique case (step_byte)
         CH_LC_N:   esc_t = CH_NL;
         CH_BSLASH: esc_t = CH_BSLASH;
         CH_QUOTE:  esc_t = CH_QUOTE;
         CH_LC_A:   esc_t = CH_BEL;
         CH_LC_B:   esc_t = CH_BS;
         CH_ZERO:   esc_t = CH_NUL;
         CH_LC_T:   esc_t = CH_TAB;
         CH_LC_R:   esc_t = CH_CR;
         CH_LC_F:   esc_t = CH_FF;
         default: begin
            esc_t     = step_byte;
            esc_known = 1'b0;
         end
      endcase
   end

   always_comb begin
      mode_in     = mode_ff;
      line_in     = lc_n;
      col_in      = cc_n;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      do_close    = 1'b0;
      close_kind  = K_DOT;
      do_start    = 1'b0;
      r0          = '0;
      r1          = '0;
      cnt         = 2'd0;

      if (step_kind == IN_END) begin
         cnt = 2'd1;
         r0  = make_res(EV_DONE, K_END, 8'd0, ERR_NONE, line_ff, col_ff);
         r1  = r0;
         unique case (mode_ff)
            M_DOT, M_INT, M_DEC, M_WORD, M_SYM: begin
               cnt = 2'd2;
               unique case (mode_ff)
                  M_DOT:   close_kind = K_DOT;
                  M_INT:   close_kind = K_INT;
                  M_DEC:   close_kind = K_DEC;
                  M_WORD:  close_kind = K_WORD;
                  default: close_kind = K_SYM;
               endcase
               r0 = make_res(EV_DONE, close_kind, 8'd0, ERR_NONE, tok_line_ff, tok_col_ff);
            end
            M_DOOT: begin
               cnt = 2'd2;
               r0  = make_res(EV_ERR, K_DOT, 8'd0, ERR_DDOT, tok_line_ff, tok_col_ff);
            end
            M_STR, M_ESC: begin
               cnt = 2'd2;
               r0  = make_res(EV_ERR, K_STR, 8'd0, ERR_UNTERM, tok_line_ff, tok_col_ff);
            end
            default: cnt = 2'd1;
         endcase
         mode_in     = M_BEGIN;
         line_in     = POS_BITS'(1);
         col_in      = '0;
         tok_line_in = POS_BITS'(1);
         tok_col_in  = '0;
      end else begin
         unique case (mode_ff)
            M_DOT: begin
               if (step_byte == CH_DOT) mode_in = M_DOOT;
               else begin
                  do_close   = 1'b1;
                  close_kind = K_DOT;
               end
            end
            M_DOOT: begin
               cnt     = 2'd1;
               mode_in = M_BEGIN;
               if (step_byte == CH_DOT)
                  r0 = make_res(EV_DONE, K_ELLIPSIS, 8'd0, ERR_NONE, tok_line_ff, tok_col_ff);
               else
                  r0 = make_res(EV_ERR, K_DOT, 8'd0, ERR_DDOT, tok_line_ff, tok_col_ff);
            end
            M_LCOM: begin
               if (step_byte == CH_NL) mode_in = M_BEGIN;
            end
            M_BCOM: begin
               if (step_byte == CH_DOLLAR) mode_in = M_BEGIN;
            end
            M_INT: begin
               if (step_byte == CH_DOT) begin
                  mode_in = M_DEC;
                  cnt     = 2'd1;
                  r0 = make_res(EV_TEXT, K_DEC, step_byte, ERR_NONE, tok_line_ff, tok_col_ff);
               end else if (is_digit(step_byte)) begin
                  cnt = 2'd1;
                  r0 = make_res(EV_TEXT, K_INT, step_byte, ERR_NONE, tok_line_ff, tok_col_ff);
               end else begin
                  do_close   = 1'b1;
                  close_kind = K_INT;
               end
            end
            M_DEC: begin
               if (is_digit(step_byte)) begin
                  cnt = 2'd1;
                  r0 = make_res(EV_TEXT, K_DEC, step_byte, ERR_NONE, tok_line_ff, tok_col_ff);
               end else begin
                  do_close   = 1'b1;
                  close_kind = K_DEC;
               end
            end
            M_WORD: begin
               if (is_word(step_byte)) begin
                  cnt = 2'd1;
                  r0 = make_res(EV_TEXT, K_WORD, step_byte, ERR_NONE, tok_line_ff, tok_col_ff);
               end else begin
                  do_close   = 1'b1;
                  close_kind = K_WORD;
               end
            end
            M_SYM: begin
               if (is_sym(step_byte)) begin
                  cnt = 2'd1;
                  r0 = make_res(EV_TEXT, K_SYM, step_byte, ERR_NONE, tok_line_ff, tok_col_ff);
               end else begin
                  do_close   = 1'b1;
                  close_kind = K_SYM;
               end
            end
            M_STR: begin
               cnt = 2'd1;
               if (step_byte == CH_NL) begin
                  mode_in = M_BEGIN;
                  r0 = make_res(EV_ERR, K_STR, 8'd0, ERR_UNTERM, tok_line_ff, tok_col_ff);
               end else if (step_byte == CH_BSLASH) begin
                  mode_in = M_ESC;
                  cnt     = 2'd0;
               end else if (step_byte == CH_QUOTE) begin
                  mode_in = M_BEGIN;
                  r0 = make_res(EV_DONE, K_STR, 8'd0, ERR_NONE, tok_line_ff, tok_col_ff);
               end else begin
                  r0 = make_res(EV_TEXT, K_STR, step_byte, ERR_NONE, tok_line_ff, tok_col_ff);
               end
            end
            M_ESC: begin
               mode_in = M_STR;
               cnt     = 2'd1;
               if (step_byte == CH_NL) begin
                  mode_in = M_BEGIN;
                  r0 = make_res(EV_ERR, K_STR, 8'd0, ERR_UNTERM, tok_line_ff, tok_col_ff);
               end else if (esc_known) begin
                  r0 = make_res(EV_TEXT, K_STR, esc_t, ERR_NONE, tok_line_ff, tok_col_ff);
               end else begin
                  cnt = 2'd2;
                  r0 = make_res(EV_TEXT, K_STR, CH_BSLASH, ERR_NONE, tok_line_ff, tok_col_ff);
                  r1 = make_res(EV_TEXT, K_STR, step_byte, ERR_NONE, tok_line_ff, tok_col_ff);
               end
            end
            default: do_start = 1'b1;
         endcase

         // pending token ends here, this byte is then handled as in M_BEGIN
         if (do_close) begin
            r0       = make_res(EV_DONE, close_kind, 8'd0, ERR_NONE, tok_line_ff, tok_col_ff);
            cnt      = 2'd1;
            do_start = 1'b1;
         end
         if (do_start) begin
            mode_in = st_mode;
            if (st_set_tok) begin
               tok_line_in = lc_n;
               tok_col_in  = cc_n;
            end
            if (st_emit) begin
               if (cnt == 2'd0) r0 = st_res;
               else r1 = st_res;
               cnt = cnt + 2'd1;
            end
         end
      end

      unique case (cnt)
         2'd1:    r0.last_result = 1'b1;
         2'd2:    r1.last_result = 1'b1;
         default: r0.last_result = 1'b0;
      endcase
   end

   assign res0    = r0;
   assign res1    = r1;
   assign res_cnt = cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_BEGIN;
         line_ff     <= POS_BITS'(1);
         col_ff      <= '0;
         tok_line_ff <= POS_BITS'(1);
         tok_col_ff  <= '0;
      end else if (step_en) begin
         mode_ff     <= mode_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
      end
   end

endmodule

// File: design/stlex_rsp_fifo.sv
// result queue taking up to two beats per cycle and giving one while out_ready is high
module stlex_rsp_fifo
   import stlex_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_cnt,
   input  rsp_type    push0,
   input  rsp_type    push1,
   output logic       space2,
   output logic       out_valid,
   input  logic       out_ready,
   output rsp_type    out_data
);

   rsp_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pop;
   logic [FIFO_PTR_W-1:0] wr_next;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign space2    = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) mem_ff[wr_ptr_ff] <= push0;
      if (push_cnt == 2'd2) mem_ff[wr_next] <= push1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/source_text_lexer_top.sv
// top level of the source text lexer: input register, lexer step, result queue
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata char_byte, tuser kind
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata token fields, tuser event, tlast
//
// one byte per cycle while each byte gives at most one beat and rsp is not stalled;
// bytes giving two beats can stall req, as the queue drains at most one beat a cycle
// a beat reaches rsp from its byte via the input register and the result queue
// synchronous reset clears mode, counters and queue pointers, no clearing pass
// a stalled rsp backs up into the 4-entry queue, then holds the input register
module source_text_lexer_top
   import stlex_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_byte
   input  logic [0:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // token_kind, text_byte, error_code, start_line, start_column, zero pad
   output logic [47:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // event_res
   output logic        rsp_tlast    // last_result
);

   logic       in_valid_ff;
   logic       in_kind_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       space2;
   logic [1:0] res_cnt;
   logic [1:0] push_cnt;
   rsp_type    res0, res1, head;

   assign advance    = in_valid_ff && space2;
   assign req_tready = !in_valid_ff || advance;
   assign push_cnt   = advance ? res_cnt : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser[0];
         in_byte_ff <= req_tdata;
      end
   end

   stlex_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_kind (in_kind_ff),
      .step_byte (in_byte_ff),
      .res0      (res0),
      .res1      (res1),
      .res_cnt   (res_cnt)
   );

   stlex_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (res0),
      .push1     (res1),
      .space2    (space2),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {1'b0, head.start_column, head.start_line, head.error_code,
                       head.text_byte, head.token_kind};
   assign rsp_tuser = head.event_res;
   assign rsp_tlast = head.last_result;

endmodule

// File: design/stlex_checker.sv
// port-level checks for the source text lexer, bound to the top level
`include "assert_macros.svh"

module stlex_checker
   import stlex_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic txt_beat;
   logic err_beat;
   logic unused_req;

   assign txt_beat   = rsp_tvalid && (rsp_tuser == EV_TEXT);
   assign err_beat   = rsp_tvalid && (rsp_tuser == EV_ERR);
   assign unused_req = req_tvalid ^ req_tready ^ (^req_tdata) ^ req_tuser[0] ^ rsp_tlast;

   `ASSERT_ALWAYS(a_quiet_after_reset, clock, reset, !rsp_tvalid, "beat right after reset")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled beat changed")
   `ASSERT_NOW(a_kind_range, clock, reset, rsp_tvalid, rsp_tdata[4:0] <= K_END, "token kind out of range")
   `ASSERT_NOW(a_text_zero, clock, reset, rsp_tvalid && !txt_beat, rsp_tdata[12:5] == 8'd0 && !unused_req || rsp_tdata[12:5] == 8'd0, "text byte on a non-text beat")
   `ASSERT_NOW(a_err_code, clock, reset, rsp_tvalid, err_beat == (rsp_tdata[14:13] != ERR_NONE), "error code and event disagree")

endmodule

bind source_text_lexer_top stlex_checker u_stlex_checker (.*);
